// ===== rtl/trs_pkg.sv =====
`default_nettype none
package trs_pkg;

    localparam int FRAC_BITS_DEF = 10;

    // widths of the fixed datapath, set by the 16-bit fields
    localparam int COORD_W = 16;
    localparam int DIST_W  = 16;
    localparam int COEF_W  = 18;   // 2*(xi - xj)
    localparam int SQ_W    = 32;   // distance squared
    localparam int ASQ_W   = 32;   // x*x + y*y of one anchor, up to 2^31
    localparam int C_W     = 35;   // right-hand side terms
    localparam int PROD_W  = 36;   // coef * coef
    localparam int DET_W   = 37;
    localparam int NP_W    = 53;   // rhs * coef
    localparam int REM_W   = 54;   // numerator magnitude
    localparam int Q_W     = 18;   // quotient magnitude; values past the 16-bit range flag overflow

    // register indexes
    localparam logic [2:0] REG_ANCHOR1_X = 3'd0;
    localparam logic [2:0] REG_ANCHOR1_Y = 3'd1;
    localparam logic [2:0] REG_ANCHOR2_X = 3'd2;
    localparam logic [2:0] REG_ANCHOR2_Y = 3'd3;
    localparam logic [2:0] REG_ANCHOR3_X = 3'd4;
    localparam logic [2:0] REG_ANCHOR3_Y = 3'd5;
    localparam logic [2:0] REG_MIN_DIST  = 3'd6;
    localparam logic [2:0] REG_MAX_DIST  = 3'd7;
    localparam int NUM_REGS = 8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BOUND = 2'd1;
    localparam logic [1:0] ST_COLIN = 2'd2;
    localparam logic [1:0] ST_CLIP  = 2'd3;

    // one item in flight through the divider chain
    typedef struct packed {
        logic             valid;
        logic             bad;     // distance out of bounds
        logic             colin;   // determinant too small
        logic             neg_x;
        logic             neg_y;
        logic [DET_W-1:0] div;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } lane_t;

endpackage
`default_nettype wire

// ===== rtl/trilateration_solver.sv =====
// pipeline from input transaction to result: 4 arithmetic stages,
//   18 divider cells, 1 output register
// throughput: one item per cycle; the whole pipe advances unless the output
//   register holds a result that is not taken
// reset: anchors, bounds and all valid flags return to defaults asynchronously
`default_nettype none
module trilateration_solver #(
    parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write port
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_addr,
    input  wire  [15:0] cfg_data,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // dist_first, dist_second, dist_third
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // pos_x, pos_y
    output logic [1:0]  m_tuser    // status
);

    localparam int NCELL = trs_pkg::Q_W;

    function automatic logic [15:0] clip_s16(input longint v);
        if (v > 32767)
            return 16'h7fff;
        else if (v < -32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [15:0] clip_u16(input longint v);
        if (v > 65535)
            return 16'hffff;
        else if (v < 0)
            return 16'h0000;
        else
            return v[15:0];
    endfunction

    // reset triangle and bounds on the fraction grid
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint HALF  = ONE_Q / 2;
    localparam longint HGT   = (433 * ONE_Q) / 1000;
    localparam logic [15:0] RST_X1 = clip_s16(0);
    localparam logic [15:0] RST_Y1 = clip_s16(HGT);
    localparam logic [15:0] RST_X2 = clip_s16(-HALF);
    localparam logic [15:0] RST_Y2 = clip_s16(-HGT);
    localparam logic [15:0] RST_X3 = clip_s16(HALF);
    localparam logic [15:0] RST_Y3 = clip_s16(-HGT);
    localparam logic [15:0] RST_LO = clip_u16(ONE_Q / 10);
    localparam logic [15:0] RST_HI = clip_u16(20 * ONE_Q);
    // |det| * 10000 < 2^(2F)  <=>  |det| < ceil(2^(2F) / 10000)
    localparam longint TWO_2F    = longint'(1) << (2 * FRAC_BITS);
    localparam longint COLIN_LIM = (TWO_2F + 9999) / 10000;

    // ---------------- configuration registers ----------------
    logic [15:0] cfg_reg [trs_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[trs_pkg::REG_ANCHOR1_X] <= RST_X1;
            cfg_reg[trs_pkg::REG_ANCHOR1_Y] <= RST_Y1;
            cfg_reg[trs_pkg::REG_ANCHOR2_X] <= RST_X2;
            cfg_reg[trs_pkg::REG_ANCHOR2_Y] <= RST_Y2;
            cfg_reg[trs_pkg::REG_ANCHOR3_X] <= RST_X3;
            cfg_reg[trs_pkg::REG_ANCHOR3_Y] <= RST_Y3;
            cfg_reg[trs_pkg::REG_MIN_DIST]  <= RST_LO;
            cfg_reg[trs_pkg::REG_MAX_DIST]  <= RST_HI;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    logic signed [15:0] x1, y1, x2, y2, x3, y3;
    assign x1 = signed'(cfg_reg[trs_pkg::REG_ANCHOR1_X]);
    assign y1 = signed'(cfg_reg[trs_pkg::REG_ANCHOR1_Y]);
    assign x2 = signed'(cfg_reg[trs_pkg::REG_ANCHOR2_X]);
    assign y2 = signed'(cfg_reg[trs_pkg::REG_ANCHOR2_Y]);
    assign x3 = signed'(cfg_reg[trs_pkg::REG_ANCHOR3_X]);
    assign y3 = signed'(cfg_reg[trs_pkg::REG_ANCHOR3_Y]);

    // whole pipe moves together; stalls only when the result is not taken
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: squares, coefficients, bounds ----------------
    logic [15:0] d1, d2, d3;
    assign d1 = s_tdata[15:0];
    assign d2 = s_tdata[31:16];
    assign d3 = s_tdata[47:32];

    logic                               v1_reg, bad1_reg;
    logic        [trs_pkg::SQ_W-1:0]    sq1_reg, sq2_reg, sq3_reg;
    logic        [trs_pkg::ASQ_W-1:0]   ak1_reg, ak2_reg, ak3_reg;
    logic signed [trs_pkg::COEF_W-1:0]  a1_reg, b1_reg, d1c_reg, e1_reg;
    logic                               bad1_next;
    logic signed [trs_pkg::COEF_W-1:0]  a1_next, b1_next, d1c_next, e1_next;

    always_comb
    begin
        bad1_next = (d1 < cfg_reg[trs_pkg::REG_MIN_DIST])
                 || (d2 < cfg_reg[trs_pkg::REG_MIN_DIST])
                 || (d3 < cfg_reg[trs_pkg::REG_MIN_DIST])
                 || (d1 > cfg_reg[trs_pkg::REG_MAX_DIST])
                 || (d2 > cfg_reg[trs_pkg::REG_MAX_DIST])
                 || (d3 > cfg_reg[trs_pkg::REG_MAX_DIST]);
        a1_next  = (trs_pkg::COEF_W'(x2) - trs_pkg::COEF_W'(x1)) <<< 1;
        b1_next  = (trs_pkg::COEF_W'(y2) - trs_pkg::COEF_W'(y1)) <<< 1;
        d1c_next = (trs_pkg::COEF_W'(x3) - trs_pkg::COEF_W'(x1)) <<< 1;
        e1_next  = (trs_pkg::COEF_W'(y3) - trs_pkg::COEF_W'(y1)) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad1_reg <= bad1_next;
            sq1_reg  <= trs_pkg::SQ_W'(d1 * d1);
            sq2_reg  <= trs_pkg::SQ_W'(d2 * d2);
            sq3_reg  <= trs_pkg::SQ_W'(d3 * d3);
            ak1_reg  <= trs_pkg::ASQ_W'(32'(x1 * x1) + 32'(y1 * y1));
            ak2_reg  <= trs_pkg::ASQ_W'(32'(x2 * x2) + 32'(y2 * y2));
            ak3_reg  <= trs_pkg::ASQ_W'(32'(x3 * x3) + 32'(y3 * y3));
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            d1c_reg  <= d1c_next;
            e1_reg   <= e1_next;
        end
    end

    // ---------------- stage 2: right-hand sides, det products ----------------
    logic                               v2_reg, bad2_reg;
    logic signed [trs_pkg::C_W-1:0]     c2_reg, f2_reg;
    logic signed [trs_pkg::COEF_W-1:0]  a2_reg, b2_reg, d2c_reg, e2_reg;
    logic signed [trs_pkg::PROD_W-1:0]  ae2_reg, bd2_reg;
    logic signed [trs_pkg::C_W-1:0]     c2_next, f2_next;

    always_comb
    begin
        c2_next = signed'(trs_pkg::C_W'(sq1_reg)) - signed'(trs_pkg::C_W'(sq2_reg))
                + signed'(trs_pkg::C_W'(ak2_reg)) - signed'(trs_pkg::C_W'(ak1_reg));
        f2_next = signed'(trs_pkg::C_W'(sq1_reg)) - signed'(trs_pkg::C_W'(sq3_reg))
                + signed'(trs_pkg::C_W'(ak3_reg)) - signed'(trs_pkg::C_W'(ak1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad2_reg <= bad1_reg;
            c2_reg   <= c2_next;
            f2_reg   <= f2_next;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            d2c_reg  <= d1c_reg;
            e2_reg   <= e1_reg;
            ae2_reg  <= trs_pkg::PROD_W'(a1_reg * e1_reg);
            bd2_reg  <= trs_pkg::PROD_W'(b1_reg * d1c_reg);
        end
    end

    // ---------------- stage 3: numerator products, determinant ----------------
    logic                             v3_reg, bad3_reg;
    logic signed [trs_pkg::NP_W-1:0]  ce3_reg, fb3_reg, af3_reg, cd3_reg;
    logic signed [trs_pkg::DET_W-1:0] det3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad3_reg <= bad2_reg;
            ce3_reg  <= trs_pkg::NP_W'(c2_reg * e2_reg);
            fb3_reg  <= trs_pkg::NP_W'(f2_reg * b2_reg);
            af3_reg  <= trs_pkg::NP_W'(a2_reg * f2_reg);
            cd3_reg  <= trs_pkg::NP_W'(c2_reg * d2c_reg);
            det3_reg <= trs_pkg::DET_W'(ae2_reg) - trs_pkg::DET_W'(bd2_reg);
        end
    end

    // ---------------- stage 4: magnitudes and signs, head of divider chain ----
    logic signed [trs_pkg::REM_W-1:0] nx, ny;
    logic        [trs_pkg::DET_W-1:0] det_mag;
    trs_pkg::lane_t                   head_next;
    trs_pkg::lane_t                   head_reg;

    always_comb
    begin
        nx      = trs_pkg::REM_W'(ce3_reg) - trs_pkg::REM_W'(fb3_reg);
        ny      = trs_pkg::REM_W'(af3_reg) - trs_pkg::REM_W'(cd3_reg);
        det_mag = det3_reg[trs_pkg::DET_W-1] ? unsigned'(-det3_reg) : unsigned'(det3_reg);
        head_next.valid = v3_reg;
        head_next.bad   = bad3_reg;
        head_next.colin = 64'(det_mag) < COLIN_LIM;
        head_next.neg_x = nx[trs_pkg::REM_W-1] ^ det3_reg[trs_pkg::DET_W-1];
        head_next.neg_y = ny[trs_pkg::REM_W-1] ^ det3_reg[trs_pkg::DET_W-1];
        head_next.div   = det_mag;
        head_next.rem_x = nx[trs_pkg::REM_W-1] ? unsigned'(-nx) : unsigned'(nx);
        head_next.rem_y = ny[trs_pkg::REM_W-1] ? unsigned'(-ny) : unsigned'(ny);
        head_next.q_x   = '0;
        head_next.q_y   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (en)
        begin
            head_reg <= head_next;
        end
    end

    // ---------------- divider chain: one quotient bit per cell, msb first ----
    trs_pkg::lane_t lane [NCELL+1];
    assign lane[0] = head_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        trs_div_cell #(
            .SHIFT (NCELL - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    // ---------------- output register: sign, saturation, status ----------------
    trs_pkg::lane_t tail;
    assign tail = lane[NCELL];

    // apply sign to a magnitude, flag values that do not fit 16 bits
    function automatic logic [16:0] apply_sign(input logic [trs_pkg::Q_W-1:0] m,
                                               input logic neg);
        if (neg)
        begin
            if (m > trs_pkg::Q_W'(32768))
                return {1'b1, 16'h8000};
            else
                return {1'b0, 16'(-m)};
        end
        else
        begin
            if (m > trs_pkg::Q_W'(32767))
                return {1'b1, 16'h7fff};
            else
                return {1'b0, m[15:0]};
        end
    endfunction

    logic [16:0] sx, sy;
    logic [15:0] px_next, py_next;
    logic [1:0]  st_next;
    logic [15:0] px_reg, py_reg;
    logic [1:0]  st_reg;

    always_comb
    begin
        sx = apply_sign(tail.q_x, tail.neg_x);
        sy = apply_sign(tail.q_y, tail.neg_y);
        px_next = sx[15:0];
        py_next = sy[15:0];
        if (tail.bad)
        begin
            st_next = trs_pkg::ST_BOUND;
            px_next = '0;
            py_next = '0;
        end
        else if (tail.colin)
        begin
            st_next = trs_pkg::ST_COLIN;
            px_next = '0;
            py_next = '0;
        end
        else if (sx[16] || sy[16])
        begin
            st_next = trs_pkg::ST_CLIP;
        end
        else
        begin
            st_next = trs_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {py_reg, px_reg};
    assign m_tuser  = st_reg;

    // ---------------- checks ----------------
    // a held result must freeze the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    // rejected items carry a zero position
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == trs_pkg::ST_BOUND || m_tuser == trs_pkg::ST_COLIN))
        |-> (m_tdata == 32'd0))
        else $error("rejected result with nonzero position");

    // a clipped result has at least one coordinate on a limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == trs_pkg::ST_CLIP)
        |-> (m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000
          || m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000))
        else $error("clipped status without saturated coordinate");

    // an accepted item never vanishes at the pipe entry (first stage)
    a_head_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item lost at pipe entry");

endmodule
`default_nettype wire

// ===== rtl/trs_div_cell.sv =====
`default_nettype none
module trs_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             en,
    input  trs_pkg::lane_t  lane_in,
    output trs_pkg::lane_t  lane_out
);

    trs_pkg::lane_t lane_reg;
    trs_pkg::lane_t lane_next;
    logic [trs_pkg::REM_W-1:0] shifted;

    // one restoring step on both coordinates
    always_comb
    begin
        shifted   = trs_pkg::REM_W'(lane_in.div) << SHIFT;
        lane_next = lane_in;
        if (lane_in.rem_x >= shifted)
        begin
            lane_next.rem_x = lane_in.rem_x - shifted;
            lane_next.q_x   = lane_in.q_x | (trs_pkg::Q_W'(1) << SHIFT);
        end
        if (lane_in.rem_y >= shifted)
        begin
            lane_next.rem_y = lane_in.rem_y - shifted;
            lane_next.q_y   = lane_in.q_y | (trs_pkg::Q_W'(1) << SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire
